@@ design/image_rotate_quarter_turns_top_defines.svh @@
// ---------------------------------------------------------------------------
// image rotate quarter turns: assertion macros
// shared concurrent assertion forms, clocked on clk and off during reset
// ---------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_QUARTER_TURNS_TOP_DEFINES_SVH
`define IMAGE_ROTATE_QUARTER_TURNS_TOP_DEFINES_SVH

// same-cycle implication
`define IRQT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irqt assertion failed");

// next-cycle implication
`define IRQT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irqt assertion failed");

`endif

@@ design/irqt_pkg.sv @@
// ---------------------------------------------------------------------------
// irqt_pkg
// constants and codes shared by the quarter-turn image rotator
// ---------------------------------------------------------------------------
package irqt_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int PIXEL_BITS_DEF = 8;

	// fixed field widths
	localparam int DIM_BITS  = 5;
	localparam int ROT_BITS  = 2;
	localparam int PIX_BITS  = 8;
	localparam int CFG_BITS  = 5;
	localparam int IDX_BITS  = 2;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(16);

	typedef enum logic [IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ROTATION     = 2'd2
	} cfg_reg_t;

	typedef enum logic [ROT_BITS-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} opcode_t;

endpackage

@@ design/irqt_ram.sv @@
// ---------------------------------------------------------------------------
// irqt_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module irqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/image_rotate_quarter_turns_top.sv @@
// ---------------------------------------------------------------------------
// image_rotate_quarter_turns_top
// frame store that loads a raster image and plays it back turned by 0..270 deg
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries requests: tuser is the opcode (load or emit), tdata the pixel.
//   a load writes the next raster pixel into the frame store and gives no result.
//   an emit gives one result on m_axis: tdata the pixel, tuser the end-of-row
//   mark, tlast the end-of-frame mark, in raster order of the turned image.
//   the cfg port writes width, height and rotation; any write to a listed
//   register restarts both the load and the emit position at zero.
// pipeline and throughput:
//   one request per cycle while s_axis_tready is high; an emit passes through
//   the frame store read stage and then the output register to reach m_axis.
//   the rate is set by the single read and single write port of the store.
// reset: positions return to zero, size to 16 by 16, rotation to zero; the
//   store contents are not cleared and no clearing pass runs.
// stall: when m_axis is held, the read stage and output register fill and
//   s_axis_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "image_rotate_quarter_turns_top_defines.svh"

module image_rotate_quarter_turns_top #(
	parameter int MAX_DIM    = irqt_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = irqt_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [irqt_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [irqt_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [irqt_pkg::PIX_BITS-1:0] s_axis_tdata,  // [7:0] pixel_in
	input  logic                          s_axis_tuser,  // [0] opcode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [irqt_pkg::PIX_BITS-1:0] m_axis_tdata,  // [7:0] pixel_out
	output logic                          m_axis_tuser,  // [0] row_end
	output logic                          m_axis_tlast   // frame_end
);

	localparam int CW          = $clog2(MAX_DIM);
	localparam int DEPTH       = MAX_DIM * MAX_DIM;
	localparam int AW          = $clog2(DEPTH);
	localparam int STORE_BITS  = (PIXEL_BITS < irqt_pkg::PIX_BITS) ?
		PIXEL_BITS : irqt_pkg::PIX_BITS;

	logic [irqt_pkg::DIM_BITS-1:0] width_q, height_q;
	irqt_pkg::rot_t                rot_q;
	logic [CW-1:0]                 load_row_q, load_col_q, emit_row_q, emit_col_q;

	logic [irqt_pkg::DIM_BITS-1:0] w_eff, h_eff, out_w, out_h;
	logic                          req_acc, load_acc, emit_acc, cfg_hit;
	logic                          load_col_end, load_row_end, rend, fend;
	logic [CW-1:0]                 src_row, src_col;
	logic [AW-1:0]                 waddr, raddr;
	logic [STORE_BITS-1:0]         rdata;

	logic                          valid_s1, rend_s1, fend_s1, s1_move;
	logic                          out_valid_q;
	logic [irqt_pkg::PIX_BITS-1:0] pix_q;
	logic                          rend_q, fend_q;

	function automatic logic [irqt_pkg::DIM_BITS-1:0] eff_dim(
		input logic [irqt_pkg::DIM_BITS-1:0] v
	);
		logic [irqt_pkg::DIM_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = irqt_pkg::DIM_BITS'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = irqt_pkg::DIM_BITS'(MAX_DIM);
		end
		return r;
	endfunction

	assign w_eff = eff_dim(width_q);
	assign h_eff = eff_dim(height_q);
	assign out_w = rot_q[0] ? h_eff : w_eff;
	assign out_h = rot_q[0] ? w_eff : h_eff;

	// handshake
	assign s1_move       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_move;
	assign req_acc       = s_axis_tvalid && s_axis_tready;
	assign load_acc      = req_acc && (s_axis_tuser == irqt_pkg::OP_LOAD);
	assign emit_acc      = req_acc && (s_axis_tuser == irqt_pkg::OP_EMIT);
	assign cfg_hit       = cfg_we && ((cfg_index == irqt_pkg::REG_IMAGE_WIDTH) ||
		(cfg_index == irqt_pkg::REG_IMAGE_HEIGHT) || (cfg_index == irqt_pkg::REG_ROTATION));

	// position wrap
	assign load_col_end = (32'(load_col_q) + 32'd1) >= 32'(w_eff);
	assign load_row_end = (32'(load_row_q) + 32'd1) >= 32'(h_eff);
	assign rend         = (32'(emit_col_q) + 32'd1) >= 32'(out_w);
	assign fend         = rend && ((32'(emit_row_q) + 32'd1) >= 32'(out_h));

	// source pixel of the turned image
	always_comb begin
		unique case (rot_q)
			irqt_pkg::ROT_90: begin
				src_row = CW'(32'(h_eff) - 32'd1 - 32'(emit_col_q));
				src_col = emit_row_q;
			end
			irqt_pkg::ROT_180: begin
				src_row = CW'(32'(h_eff) - 32'd1 - 32'(emit_row_q));
				src_col = CW'(32'(w_eff) - 32'd1 - 32'(emit_col_q));
			end
			irqt_pkg::ROT_270: begin
				src_row = emit_col_q;
				src_col = CW'(32'(w_eff) - 32'd1 - 32'(emit_row_q));
			end
			default: begin
				src_row = emit_row_q;
				src_col = emit_col_q;
			end
		endcase
	end

	assign waddr = AW'(AW'(load_row_q) * AW'(MAX_DIM) + AW'(load_col_q));
	assign raddr = AW'(AW'(src_row) * AW'(MAX_DIM) + AW'(src_col));

	irqt_ram #(
		.WIDTH (STORE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_acc),
		.waddr (waddr),
		.wdata (s_axis_tdata[STORE_BITS-1:0]),
		.re    (emit_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// registers and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= irqt_pkg::DIM_RESET;
			height_q   <= irqt_pkg::DIM_RESET;
			rot_q      <= irqt_pkg::ROT_0;
			load_row_q <= '0;
			load_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				irqt_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				irqt_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: rot_q <= irqt_pkg::rot_t'(cfg_wdata[irqt_pkg::ROT_BITS-1:0]);
			endcase
			load_row_q <= '0;
			load_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else begin
			if (load_acc) begin
				if (load_col_end) begin
					load_col_q <= '0;
					load_row_q <= load_row_end ? '0 : load_row_q + CW'(1);
				end else begin
					load_col_q <= load_col_q + CW'(1);
				end
			end
			if (emit_acc) begin
				if (rend) begin
					emit_col_q <= '0;
					emit_row_q <= fend ? '0 : emit_row_q + CW'(1);
				end else begin
					emit_col_q <= emit_col_q + CW'(1);
				end
			end
		end
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_acc) begin
			rend_s1 <= rend;
			fend_s1 <= fend;
		end
		if (s1_move && valid_s1) begin
			pix_q  <= irqt_pkg::PIX_BITS'(rdata);
			rend_q <= rend_s1;
			fend_q <= fend_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pix_q;
	assign m_axis_tuser  = rend_q;
	assign m_axis_tlast  = fend_q;

	// checks
	`IRQT_ASSERT_NOW(a_frame_end_ends_row, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
	`IRQT_ASSERT_NOW(a_emit_pos_in_frame, 1'b1,
		(32'(emit_col_q) < 32'(out_w)) && (32'(emit_row_q) < 32'(out_h)))
	`IRQT_ASSERT_NEXT(a_read_stage_holds, valid_s1 && !s1_move && !cfg_we, valid_s1)

endmodule

@@ tb/image_rotate_quarter_turns_top_test.sv @@
// ---------------------------------------------------------------------------
// image_rotate_quarter_turns_top_test
// loads small raster images into the frame store and reads them back turned
// by each quarter turn; every emitted pixel and its row and frame marks are
// compared with a predictor that keeps its own store, counters and settings
// ---------------------------------------------------------------------------
module image_rotate_quarter_turns_top_test;
	import irqt_pkg::*;

	localparam int STORE_DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int TARGET_ITEMS = 1600;
	localparam int IDLE_LIMIT   = 2000;
	localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [DIM_BITS-1:0] width_reg;
		logic [DIM_BITS-1:0] height_reg;
		rot_t                turn;
		int                  load_row;
		int                  load_col;
		int                  emit_row;
		int                  emit_col;
	} raster_state_t;

	typedef struct {
		opcode_t             op;
		logic [PIX_BITS-1:0] pixel;
	} request_t;

	typedef struct {
		logic [PIX_BITS-1:0] pixel;
		logic                row_end;
		logic                frame_end;
	} pixel_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PIX_BITS-1:0] s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [PIX_BITS-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;

	image_rotate_quarter_turns_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- raster arithmetic shared by planner and predictor

	function automatic int eff_dim(logic [DIM_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(v);
	endfunction

	function automatic raster_state_t reset_state();
		raster_state_t s;
		s.width_reg  = DIM_RESET;
		s.height_reg = DIM_RESET;
		s.turn       = ROT_0;
		s.load_row   = 0;
		s.load_col   = 0;
		s.emit_row   = 0;
		s.emit_col   = 0;
		return s;
	endfunction

	function automatic bit quarter_odd(raster_state_t s);
		return s.turn == ROT_90 || s.turn == ROT_270;
	endfunction

	function automatic int out_cols(raster_state_t s);
		return quarter_odd(s) ? eff_dim(s.height_reg) : eff_dim(s.width_reg);
	endfunction

	function automatic int out_rows(raster_state_t s);
		return quarter_odd(s) ? eff_dim(s.width_reg) : eff_dim(s.height_reg);
	endfunction

	function automatic int load_index(raster_state_t s);
		return s.load_row * MAX_DIM_DEF + s.load_col;
	endfunction

	// store entry that the next emitted pixel comes from
	function automatic int source_index(raster_state_t s);
		int w;
		int h;
		int sr;
		int sc;
		w = eff_dim(s.width_reg);
		h = eff_dim(s.height_reg);
		case (s.turn)
			ROT_90: begin
				sr = h - 1 - s.emit_col;
				sc = s.emit_row;
			end
			ROT_180: begin
				sr = h - 1 - s.emit_row;
				sc = w - 1 - s.emit_col;
			end
			ROT_270: begin
				sr = s.emit_col;
				sc = w - 1 - s.emit_row;
			end
			default: begin
				sr = s.emit_row;
				sc = s.emit_col;
			end
		endcase
		return sr * MAX_DIM_DEF + sc;
	endfunction

	function automatic bit row_done(raster_state_t s);
		return s.emit_col + 1 >= out_cols(s);
	endfunction

	function automatic bit frame_done(raster_state_t s);
		return row_done(s) && s.emit_row + 1 >= out_rows(s);
	endfunction

	function automatic raster_state_t after_load(raster_state_t s);
		if (s.load_col + 1 >= eff_dim(s.width_reg)) begin
			s.load_col = 0;
			s.load_row = (s.load_row + 1 >= eff_dim(s.height_reg)) ? 0 : s.load_row + 1;
		end else begin
			s.load_col++;
		end
		return s;
	endfunction

	function automatic raster_state_t after_emit(raster_state_t s);
		if (frame_done(s)) begin
			s.emit_col = 0;
			s.emit_row = 0;
		end else if (row_done(s)) begin
			s.emit_col = 0;
			s.emit_row++;
		end else begin
			s.emit_col++;
		end
		return s;
	endfunction

	// a write to a listed register restarts both positions
	function automatic raster_state_t apply_reg(raster_state_t s, logic [IDX_BITS-1:0] idx,
			logic [CFG_BITS-1:0] value);
		case (idx)
			REG_IMAGE_WIDTH:  s.width_reg = value;
			REG_IMAGE_HEIGHT: s.height_reg = value;
			REG_ROTATION:     s.turn = rot_t'(value[ROT_BITS-1:0]);
			default:          return s;
		endcase
		s.load_row = 0;
		s.load_col = 0;
		s.emit_row = 0;
		s.emit_col = 0;
		return s;
	endfunction

	// ---------------- request planning

	request_t      pending_requests[$];
	raster_state_t plan = reset_state();
	bit            plan_written[STORE_DEPTH];
	int            items_planned = 0;
	int            reg_writes = 0;

	// an emit whose source entry was never loaded turns into a load
	task automatic plan_request(opcode_t op, logic [PIX_BITS-1:0] pixel);
		request_t r;
		r.op = op;
		r.pixel = pixel;
		if (op == OP_EMIT && !plan_written[source_index(plan)])
			r.op = OP_LOAD;
		if (r.op == OP_LOAD) begin
			plan_written[load_index(plan)] = 1'b1;
			plan = after_load(plan);
		end else begin
			plan = after_emit(plan);
		end
		pending_requests.push_back(r);
		items_planned++;
	endtask

	task automatic plan_frame(opcode_t op, int count);
		repeat (count) plan_request(op, PIX_BITS'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		plan = apply_reg(plan, idx, value);
		reg_writes++;
	endtask

	// mostly small sizes, sometimes the full store or an out-of-range value
	function automatic logic [CFG_BITS-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return CFG_BITS'($urandom_range(1, 5));
		if (r < 17)
			return CFG_BITS'($urandom_range(6, 16));
		if (r == 17)
			return '0;
		return CFG_BITS'($urandom_range(17, 31));
	endfunction

	// ---------------- sender

	request_t next_req;
	int       burst_left = 1;
	int       gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				next_req = pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= next_req.op;
				s_axis_tdata <= next_req.pixel;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- receiver

	int rx_cycle = 0;
	int rx_results = 0;
	int hold_left = 0;
	int holds_done = 0;
	int hold_at = 100;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (m_axis_tvalid && m_axis_tready)
				rx_results++;
			// long hold-off while requests are still queued, so the block backs up
			if (hold_left == 0 && holds_done < 3 && rx_results >= hold_at && s_axis_tvalid
					&& pending_requests.size() >= 8) begin
				hold_left = 120;
				holds_done++;
				hold_at = rx_results + 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 256) % 4)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= (rx_cycle % 3 == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// ---------------- predictor and checker

	raster_state_t       rot_model = reset_state();
	logic [PIX_BITS-1:0] model_store[STORE_DEPTH];
	pixel_result_t       expected_pixels[$];
	pixel_result_t       want;
	pixel_result_t       pred;
	int                  requests_taken = 0;
	int                  loads_taken = 0;
	int                  emits_taken = 0;
	int                  frames_seen = 0;
	int                  failures = 0;
	logic [3:0]          turns_seen = '0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (m_axis_tlast === 1'b1)
					frames_seen++;
				if (expected_pixels.size() == 0) begin
					$error("result with no emit request waiting: pixel_out %0d", m_axis_tdata);
					failures++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_axis_tdata !== want.pixel) begin
						$error("pixel_out mismatch: expected %0d, got %0d", want.pixel,
							m_axis_tdata);
						failures++;
					end
					if (m_axis_tuser !== want.row_end) begin
						$error("row_end mismatch: expected %0d, got %0d", want.row_end,
							m_axis_tuser);
						failures++;
					end
					if (m_axis_tlast !== want.frame_end) begin
						$error("frame_end mismatch: expected %0d, got %0d", want.frame_end,
							m_axis_tlast);
						failures++;
					end
				end
			end
			if (cfg_we)
				rot_model = apply_reg(rot_model, cfg_index, cfg_wdata);
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_LOAD) begin
					model_store[load_index(rot_model)] = s_axis_tdata;
					rot_model = after_load(rot_model);
					loads_taken++;
				end else begin
					pred.pixel = model_store[source_index(rot_model)];
					pred.row_end = row_done(rot_model);
					pred.frame_end = frame_done(rot_model);
					turns_seen[rot_model.turn] = 1'b1;
					expected_pixels.push_back(pred);
					rot_model = after_emit(rot_model);
					emits_taken++;
				end
				requests_taken++;
			end
		end
	end

	// ---------------- watchdog

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- stimulus

	// loads have no result, so allow the store write to finish as well
	task automatic wait_idle();
		while (requests_taken != items_planned || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase;
		int mode;
		int frame_px;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default 16 by 16, no turn: pixel extremes straight back
		plan_request(OP_LOAD, 8'h00);
		plan_request(OP_LOAD, 8'hFF);
		plan_request(OP_EMIT, 8'hFF);
		plan_request(OP_EMIT, 8'h00);
		wait_idle();

		// zero sizes act as one pixel; rotation with spare high bits set
		write_reg(REG_IMAGE_WIDTH, 5'd0);
		write_reg(REG_IMAGE_HEIGHT, 5'd0);
		write_reg(REG_ROTATION, 5'b11111);
		plan_request(OP_LOAD, 8'hA5);
		plan_request(OP_EMIT, 8'h00);
		plan_request(OP_EMIT, 8'hFF);
		wait_idle();

		// 3 wide, 2 high, quarter turn: output is 2 wide, 3 high, then wraps
		write_reg(REG_IMAGE_WIDTH, 5'd3);
		write_reg(REG_IMAGE_HEIGHT, 5'd2);
		write_reg(REG_ROTATION, 5'(ROT_90));
		plan_request(OP_LOAD, 8'h5A);
		plan_request(OP_LOAD, 8'h80);
		plan_request(OP_LOAD, 8'h01);
		plan_request(OP_LOAD, 8'h7F);
		plan_request(OP_LOAD, 8'hC3);
		plan_request(OP_LOAD, 8'h3C);
		plan_frame(OP_EMIT, 7);
		wait_idle();

		phase = 0;
		while (items_planned < TARGET_ITEMS) begin
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(REG_IMAGE_WIDTH, (phase == 0) ? 5'd31 : pick_dim());
			if (phase <= 1 || $urandom_range(0, 2) != 0)
				write_reg(REG_IMAGE_HEIGHT, (phase == 1) ? 5'd16 : pick_dim());
			if (phase == 0 || $urandom_range(0, 2) == 0)
				write_reg(REG_ROTATION, CFG_BITS'($urandom_range(0, 31)));
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, CFG_BITS'($urandom_range(0, 31)));

			frame_px = eff_dim(plan.width_reg) * eff_dim(plan.height_reg);
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				// whole frame in, then one or two turned frames out
				plan_frame(OP_LOAD, frame_px);
				plan_frame(OP_EMIT, frame_px * $urandom_range(1, 2));
			end else if (mode < 8) begin
				repeat ($urandom_range(8, 40))
					plan_request(($urandom_range(0, 4) < 2) ? OP_LOAD : OP_EMIT,
						PIX_BITS'($urandom_range(0, 255)));
			end else begin
				// part of a frame in and out, at most a whole frame each
				plan_frame(OP_LOAD, $urandom_range(1, frame_px));
				plan_frame(OP_EMIT, $urandom_range(1, frame_px));
			end
			wait_idle();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d emitted pixels never arrived", expected_pixels.size());
			failures++;
		end
		$display("covered %0d loads and %0d emits in %0d phases with %0d register writes",
			loads_taken, emits_taken, phase + 3, reg_writes);
		$display("%0d turned frames completed, turns used (270..0) %b", frames_seen, turns_seen);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
